/* design/lr_pkg.sv */
// Shared constants and command codes for the line rasterizer.
package lr_pkg;

  localparam int DEFAULT_COORD_BITS = 8;
  localparam int DEFAULT_COLOR_BITS = 16;
  localparam int DEFAULT_QUEUE_DEPTH = 4;

  // Command codes carried on the cmd field.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

endpackage

/* design/lr_queue.sv */
// Small first-in first-out queue between the front and back parts.
module lr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic do_wr;
  logic do_rd;

  assign full    = (count == FULL_COUNT);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("queue count beyond depth");

  a_write_grows: assert property (@(posedge clk) disable iff (rst)
    (do_wr && !do_rd) |=> !empty)
    else $error("queue empty after an unmatched write");

endmodule

/* design/lr_front.sv */
// Front part: accepts transactions, prepares line setup, feeds the queue.
module lr_front #(
  parameter int COORD_BITS = 8,
  parameter int COLOR_BITS = 16,
  parameter int ENTRY_W = 3 + 5 * COORD_BITS + COLOR_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  logic                  cmd,
  input  logic [COORD_BITS-1:0] x_start,
  input  logic [COORD_BITS-1:0] y_start,
  input  logic [COORD_BITS-1:0] x_end,
  input  logic [COORD_BITS-1:0] y_end,
  input  logic [COLOR_BITS-1:0] color_in,
  output logic                  q_wr_en,
  output logic [ENTRY_W-1:0]    q_wr_data,
  input  logic                  q_full
);
  import lr_pkg::*;

  typedef struct packed {
    logic                  kind;
    logic                  steep;
    logic                  down;
    logic [COORD_BITS-1:0] major_pos;
    logic [COORD_BITS-1:0] major_stop;
    logic [COORD_BITS-1:0] minor_pos;
    logic [COORD_BITS-1:0] delta_major;
    logic [COORD_BITS-1:0] delta_minor;
    logic [COLOR_BITS-1:0] color;
  } entry_t;

  // First stage registers: endpoints already swapped for steep lines.
  logic                  s1_valid;
  logic                  s1_kind;
  logic                  s1_steep;
  logic [COORD_BITS-1:0] s1_ax;
  logic [COORD_BITS-1:0] s1_ay;
  logic [COORD_BITS-1:0] s1_bx;
  logic [COORD_BITS-1:0] s1_by;
  logic [COLOR_BITS-1:0] s1_color;

  logic                  accept;
  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic                  steep;
  logic                  flip;
  logic [COORD_BITS-1:0] p_major;
  logic [COORD_BITS-1:0] p_stop;
  logic [COORD_BITS-1:0] p_minor;
  logic [COORD_BITS-1:0] p_minor_end;
  entry_t                entry;

  assign cmd_stall = s1_valid && q_full;
  assign accept    = cmd_valid && !cmd_stall;

  assign dx    = (x_start > x_end) ? x_start - x_end : x_end - x_start;
  assign dy    = (y_start > y_end) ? y_start - y_end : y_end - y_start;
  assign steep = dy > dx;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (!q_full) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind  <= cmd;
      s1_steep <= steep;
      s1_ax    <= steep ? y_start : x_start;
      s1_ay    <= steep ? x_start : y_start;
      s1_bx    <= steep ? y_end : x_end;
      s1_by    <= steep ? x_end : y_end;
      s1_color <= color_in;
    end
  end

  // Order the endpoints so the major coordinate increases.
  assign flip        = s1_ax > s1_bx;
  assign p_major     = flip ? s1_bx : s1_ax;
  assign p_stop      = flip ? s1_ax : s1_bx;
  assign p_minor     = flip ? s1_by : s1_ay;
  assign p_minor_end = flip ? s1_ay : s1_by;

  always_comb begin
    entry.kind        = s1_kind;
    entry.steep       = s1_steep;
    entry.down        = !(p_minor < p_minor_end);
    entry.major_pos   = p_major;
    entry.major_stop  = p_stop;
    entry.minor_pos   = p_minor;
    entry.delta_major = p_stop - p_major;
    entry.delta_minor = (p_minor > p_minor_end) ? p_minor - p_minor_end
                                                : p_minor_end - p_minor;
    entry.color       = s1_color;
  end

  assign q_wr_en   = s1_valid && !q_full;
  assign q_wr_data = ENTRY_W'(entry);

  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |=> s1_valid)
    else $error("front stage lost its transaction while stalled");

  a_step_classified: assert property (@(posedge clk) disable iff (rst)
    (q_wr_en && s1_kind == CMD_START) |-> (entry.major_pos <= entry.major_stop))
    else $error("start entry pushed with endpoints out of order");

endmodule

/* design/lr_back.sv */
// Back part: runs the Bresenham stepping and holds the pixel output register.
module lr_back #(
  parameter int COORD_BITS = 8,
  parameter int COLOR_BITS = 16,
  parameter int ENTRY_W = 3 + 5 * COORD_BITS + COLOR_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  logic [ENTRY_W-1:0]    q_rd_data,
  output logic                  q_rd_en,
  output logic                  pixel_valid,
  input  logic                  pixel_stall,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic [COLOR_BITS-1:0] color_out,
  output logic                  last
);
  import lr_pkg::*;

  localparam int EW = COORD_BITS + 2;

  typedef struct packed {
    logic                  kind;
    logic                  steep;
    logic                  down;
    logic [COORD_BITS-1:0] major_pos;
    logic [COORD_BITS-1:0] major_stop;
    logic [COORD_BITS-1:0] minor_pos;
    logic [COORD_BITS-1:0] delta_major;
    logic [COORD_BITS-1:0] delta_minor;
    logic [COLOR_BITS-1:0] color;
  } entry_t;

  entry_t                head;
  logic                  busy;
  logic                  is_steep;
  logic                  minor_down;
  logic [COORD_BITS-1:0] major_pos;
  logic [COORD_BITS-1:0] major_stop;
  logic [COORD_BITS-1:0] minor_pos;
  logic [COORD_BITS-1:0] delta_major;
  logic [COORD_BITS-1:0] delta_minor;
  logic [COLOR_BITS-1:0] line_color;
  logic signed [EW-1:0]  error_acc;

  logic                  pop;
  logic                  is_start;
  logic                  emit;
  logic                  fin;
  logic signed [EW-1:0]  err_sub;
  logic signed [EW-1:0]  error_acc_next;

  assign head     = entry_t'(q_rd_data);
  assign pop      = !q_empty && !(pixel_valid && pixel_stall);
  assign q_rd_en  = pop;
  assign is_start = (head.kind == CMD_START);
  assign emit     = pop && !is_start && busy;
  assign fin      = (major_pos == major_stop);

  assign err_sub = error_acc - $signed({2'b00, delta_minor});
  assign error_acc_next = err_sub[EW-1] ? err_sub + $signed({2'b00, delta_major})
                                        : err_sub;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      error_acc <= '0;
    end else if (pop && is_start) begin
      busy      <= 1'b1;
      error_acc <= $signed({2'b00, head.delta_major >> 1});
    end else if (emit) begin
      busy      <= !fin;
      error_acc <= error_acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_start) begin
      is_steep    <= head.steep;
      minor_down  <= head.down;
      major_pos   <= head.major_pos;
      major_stop  <= head.major_stop;
      minor_pos   <= head.minor_pos;
      delta_major <= head.delta_major;
      delta_minor <= head.delta_minor;
      line_color  <= head.color;
    end else if (emit) begin
      major_pos <= major_pos + COORD_BITS'(1);
      if (err_sub[EW-1]) begin
        minor_pos <= minor_down ? minor_pos - COORD_BITS'(1)
                                : minor_pos + COORD_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (emit) begin
      pixel_valid <= 1'b1;
    end else if (!pixel_stall) begin
      pixel_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_x   <= is_steep ? minor_pos : major_pos;
      pixel_y   <= is_steep ? major_pos : minor_pos;
      color_out <= line_color;
      last      <= fin;
    end
  end

  a_error_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (error_acc >= 0 && error_acc <= $signed({2'b00, delta_major})))
    else $error("error accumulator out of range");

  a_major_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (major_pos <= major_stop))
    else $error("major coordinate passed the stop point");

endmodule

/* design/line_rasterizer.sv */
// Top level of the Bresenham line rasterizer.
//
// Input channel (cmd_valid / cmd_stall): one transaction is either a start
// command (cmd = 0) that loads two endpoints and a color, or a step command
// (cmd = 1) that asks for the next pixel. A start emits nothing; a step while
// no line is active emits nothing. Steep lines have their axes swapped and the
// endpoints are ordered by the major axis, so pixels may begin at either end.
// Both endpoints are drawn, and the final pixel carries last = 1.
//
// Output channel (pixel_valid / pixel_stall): one pixel per useful step.
// A step passes the front stage register and the four-entry queue before its
// pixel enters the output register. While pixel_stall is low, both channels
// sustain one transaction per clock. Each pixel update subtracts delta_minor
// from the error accumulator and adds delta_major back if the result is negative.
//
// When the receiver stalls, the output register holds its pixel and the queue
// absorbs further commands; cmd_stall rises only once the queue is full and
// the front stage holds a transaction. Reset (rst, synchronous, active high)
// empties the queue and the output register and leaves no line active.
module line_rasterizer #(
  parameter int COORD_BITS = lr_pkg::DEFAULT_COORD_BITS,
  parameter int COLOR_BITS = lr_pkg::DEFAULT_COLOR_BITS,
  parameter int QUEUE_DEPTH = lr_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  logic                  cmd,
  input  logic [COORD_BITS-1:0] x_start,
  input  logic [COORD_BITS-1:0] y_start,
  input  logic [COORD_BITS-1:0] x_end,
  input  logic [COORD_BITS-1:0] y_end,
  input  logic [COLOR_BITS-1:0] color_in,
  output logic                  pixel_valid,
  input  logic                  pixel_stall,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic [COLOR_BITS-1:0] color_out,
  output logic                  last
);
  import lr_pkg::*;

  // A queue entry holds the kind, steep and direction flags, five coordinate
  // values and the color.
  localparam int ENTRY_W = 3 + 5 * COORD_BITS + COLOR_BITS;

  logic               q_wr_en;
  logic [ENTRY_W-1:0] q_wr_data;
  logic               q_full;
  logic               q_rd_en;
  logic [ENTRY_W-1:0] q_rd_data;
  logic               q_empty;

  // The front stage classifies commands and prepares line setup values.
  lr_front #(
    .COORD_BITS(COORD_BITS),
    .COLOR_BITS(COLOR_BITS),
    .ENTRY_W(ENTRY_W)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .x_start(x_start),
    .y_start(y_start),
    .x_end(x_end),
    .y_end(y_end),
    .color_in(color_in),
    .q_wr_en(q_wr_en),
    .q_wr_data(q_wr_data),
    .q_full(q_full)
  );

  // The queue decouples command intake from pixel generation.
  lr_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .wr_en(q_wr_en),
    .wr_data(q_wr_data),
    .full(q_full),
    .rd_en(q_rd_en),
    .rd_data(q_rd_data),
    .empty(q_empty)
  );

  // The back part runs the stepping and owns the pixel output register.
  lr_back #(
    .COORD_BITS(COORD_BITS),
    .COLOR_BITS(COLOR_BITS),
    .ENTRY_W(ENTRY_W)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_empty(q_empty),
    .q_rd_data(q_rd_data),
    .q_rd_en(q_rd_en),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel_x(pixel_x),
    .pixel_y(pixel_y),
    .color_out(color_out),
    .last(last)
  );

endmodule
